[hw/rtl/lbb_pkg.sv]
`default_nettype none
package lbb_pkg;
	localparam int unsigned ColorW  = 3;
	localparam int unsigned CountW  = 8;
	localparam int unsigned DurW    = 16;
	localparam int unsigned OriginW = 32;
	localparam int unsigned NowW    = 32;
	localparam int unsigned PeriodW = 25;
	localparam int unsigned BlinkW  = 17;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 32;

	typedef enum logic [CfgIdxW-1:0] {
		REG_COLOR_MASK  = 3'd0,
		REG_BLINK_COUNT = 3'd1,
		REG_ON_TICKS    = 3'd2,
		REG_OFF_TICKS   = 3'd3,
		REG_PAUSE_TICKS = 3'd4,
		REG_START_ON    = 3'd5,
		REG_ORIGIN      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [ColorW-1:0]  color_mask;
		logic               start_on;
		logic [DurW-1:0]    on_ticks;
		logic [DurW-1:0]    off_ticks;
		logic [OriginW-1:0] origin;
		logic [PeriodW-1:0] burst;
		logic [PeriodW-1:0] period;
		logic [BlinkW-1:0]  blink_len;
	} cfg_t;
endpackage
`default_nettype wire

[hw/rtl/lbb_in_if.sv]
`default_nettype none
interface lbb_in_if;
	logic                      valid;
	logic                      ready;
	logic [lbb_pkg::NowW-1:0]  now_tick;
	modport source (output valid, output now_tick, input ready);
	modport sink (input valid, input now_tick, output ready);
endinterface
`default_nettype wire

[hw/rtl/lbb_out_if.sv]
`default_nettype none
interface lbb_out_if;
	logic                        valid;
	logic                        ready;
	logic [lbb_pkg::ColorW-1:0]  led_enable;
	logic [lbb_pkg::PeriodW-1:0] ticks_to_change;
	logic                        period_error;
	modport source (output valid, output led_enable, output ticks_to_change,
		output period_error, input ready);
	modport sink (input valid, input led_enable, input ticks_to_change,
		input period_error, output ready);
endinterface
`default_nettype wire

[hw/rtl/lbb_cfg_if.sv]
`default_nettype none
interface lbb_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [lbb_pkg::CfgIdxW-1:0]  index;
	logic [lbb_pkg::CfgDatW-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/lbb_cfg_regs.sv]
`default_nettype none
module lbb_cfg_regs (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lbb_cfg_if.sink     cfg,
	output lbb_pkg::cfg_t cfg_out
);
	logic [lbb_pkg::ColorW-1:0]  color_mask_q;
	logic [lbb_pkg::CountW-1:0]  blink_count_q;
	logic [lbb_pkg::DurW-1:0]    on_ticks_q;
	logic [lbb_pkg::DurW-1:0]    off_ticks_q;
	logic [lbb_pkg::DurW-1:0]    pause_ticks_q;
	logic                        start_on_q;
	logic [lbb_pkg::OriginW-1:0] origin_q;
	logic [lbb_pkg::PeriodW-1:0] burst_q;
	logic [lbb_pkg::PeriodW-1:0] period_q;
	logic [lbb_pkg::BlinkW-1:0]  blink_len_q;
	logic [lbb_pkg::PeriodW-1:0] burst_d;
	logic [lbb_pkg::CountW-1:0]  off_count;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mask_q  <= '0;
			blink_count_q <= lbb_pkg::CountW'(1);
			on_ticks_q    <= '0;
			off_ticks_q   <= '0;
			pause_ticks_q <= '0;
			start_on_q    <= 1'b0;
			origin_q      <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lbb_pkg::REG_COLOR_MASK:  color_mask_q  <= cfg.data[lbb_pkg::ColorW-1:0];
				lbb_pkg::REG_BLINK_COUNT: blink_count_q <= cfg.data[lbb_pkg::CountW-1:0];
				lbb_pkg::REG_ON_TICKS:    on_ticks_q    <= cfg.data[lbb_pkg::DurW-1:0];
				lbb_pkg::REG_OFF_TICKS:   off_ticks_q   <= cfg.data[lbb_pkg::DurW-1:0];
				lbb_pkg::REG_PAUSE_TICKS: pause_ticks_q <= cfg.data[lbb_pkg::DurW-1:0];
				lbb_pkg::REG_START_ON:    start_on_q    <= cfg.data[0];
				lbb_pkg::REG_ORIGIN:      origin_q      <= cfg.data[lbb_pkg::OriginW-1:0];
				default: ;
			endcase
		end
	end

	// derived timing, settles in the cycle after a write
	assign off_count = blink_count_q - lbb_pkg::CountW'(start_on_q);
	always_comb begin
		burst_d = '0;
		if (blink_count_q != '0)
			burst_d = lbb_pkg::PeriodW'(blink_count_q) * lbb_pkg::PeriodW'(on_ticks_q)
				+ lbb_pkg::PeriodW'(off_count) * lbb_pkg::PeriodW'(off_ticks_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q     <= '0;
			period_q    <= '0;
			blink_len_q <= '0;
		end else begin
			burst_q     <= burst_d;
			period_q    <= burst_d + lbb_pkg::PeriodW'(pause_ticks_q);
			blink_len_q <= lbb_pkg::BlinkW'(on_ticks_q) + lbb_pkg::BlinkW'(off_ticks_q);
		end
	end

	always_comb begin
		cfg_out.color_mask = color_mask_q;
		cfg_out.start_on   = start_on_q;
		cfg_out.on_ticks   = on_ticks_q;
		cfg_out.off_ticks  = off_ticks_q;
		cfg_out.origin     = origin_q;
		cfg_out.burst      = burst_q;
		cfg_out.period     = period_q;
		cfg_out.blink_len  = blink_len_q;
	end
endmodule
`default_nettype wire

[hw/rtl/lbb_mod_pipe.sv]
`default_nettype none
// remainder of dividend by divisor, one restoring step per stage
module lbb_mod_pipe #(
	parameter int unsigned DW = 32,
	parameter int unsigned VW = 25,
	parameter int unsigned SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          vld_in,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	input  wire logic [SW-1:0] side_in,
	output logic               vld_out,
	output logic [VW-1:0]      remainder,
	output logic [SW-1:0]      side_out
);
	logic [VW-1:0] rem_s  [DW+1];
	logic [DW-1:0] dvd_s  [DW+1];
	logic [SW-1:0] side_s [DW+1];
	logic          vld_s  [DW+1];

	assign rem_s[0]  = '0;
	assign dvd_s[0]  = dividend;
	assign side_s[0] = side_in;
	assign vld_s[0]  = vld_in;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [VW:0] wide;
		logic [VW:0] diff;
		logic        ge;
		assign wide = {rem_s[k], dvd_s[k][DW-1]};
		assign diff = wide - {1'b0, divisor};
		assign ge   = wide >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else if (en)
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[VW-1:0] : wide[VW-1:0];
				dvd_s[k+1]  <= dvd_s[k] << 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_out   = vld_s[DW];
	assign remainder = rem_s[DW];
	assign side_out  = side_s[DW];
endmodule
`default_nettype wire

[hw/rtl/led_blink_burst_pattern.sv]
`default_nettype none
// channel  dir  handshake      payload
// in_ch    in   valid/ready    now_tick[31:0]
// out_ch   out  valid/ready    led_enable[2:0], ticks_to_change[24:0], period_error
// cfg      in   valid/ready    index[2:0], data[31:0]
//
// one item per cycle while the output does not stall; stages: one for the tick
// difference, one restoring step per stage for each of the two remainders, one
// output stage. the whole pipeline holds while the output item waits. reset
// clears all valid bits and loads register defaults. cfg is always ready.
module led_blink_burst_pattern #(
	parameter int unsigned TICK_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lbb_in_if.sink    in_ch,
	lbb_out_if.source out_ch,
	lbb_cfg_if.sink   cfg
);
	lbb_pkg::cfg_t cfg_v;
	logic          en;

	logic                 vld_s1;
	logic [TICK_BITS-1:0] diff_s1;

	logic                        vld_m1;
	logic [lbb_pkg::PeriodW-1:0] elapsed_m1;
	logic                        vld_m2;
	logic [lbb_pkg::BlinkW-1:0]  phase_m2;
	logic [lbb_pkg::PeriodW-1:0] elapsed_m2;
	logic [lbb_pkg::BlinkW-1:0]  phase_in;

	logic                        out_vld_q;
	logic [lbb_pkg::ColorW-1:0]  led_q;
	logic [lbb_pkg::PeriodW-1:0] next_q;
	logic                        err_q;

	logic                        lit;
	logic [lbb_pkg::PeriodW-1:0] next_d;
	logic [lbb_pkg::BlinkW-1:0]  on_w;
	logic [lbb_pkg::BlinkW-1:0]  off_w;

	lbb_cfg_regs u_cfg (.clk(clk), .arst_n(arst_n), .cfg(cfg), .cfg_out(cfg_v));

	assign en          = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en)
			diff_s1 <= TICK_BITS'(in_ch.now_tick) - TICK_BITS'(cfg_v.origin);
	end

	lbb_mod_pipe #(.DW(TICK_BITS), .VW(lbb_pkg::PeriodW), .SW(1)) u_mod_period (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_s1), .dividend(diff_s1), .divisor(cfg_v.period),
		.side_in(1'b0), .vld_out(vld_m1), .remainder(elapsed_m1), .side_out()
	);

	lbb_mod_pipe #(.DW(lbb_pkg::PeriodW), .VW(lbb_pkg::BlinkW), .SW(lbb_pkg::PeriodW))
	u_mod_blink (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vld_m1), .dividend(elapsed_m1), .divisor(cfg_v.blink_len),
		.side_in(elapsed_m1), .vld_out(vld_m2), .remainder(phase_in),
		.side_out(elapsed_m2)
	);
	assign phase_m2 = phase_in;

	assign on_w  = lbb_pkg::BlinkW'(cfg_v.on_ticks);
	assign off_w = lbb_pkg::BlinkW'(cfg_v.off_ticks);

	always_comb begin
		lit    = 1'b0;
		next_d = cfg_v.period - elapsed_m2;
		if (elapsed_m2 < cfg_v.burst && cfg_v.blink_len != '0) begin
			if (cfg_v.start_on) begin
				lit    = phase_m2 < on_w;
				next_d = lbb_pkg::PeriodW'(lit ? on_w - phase_m2
					: cfg_v.blink_len - phase_m2);
			end else begin
				lit    = phase_m2 >= off_w;
				next_d = lbb_pkg::PeriodW'(lit ? cfg_v.blink_len - phase_m2
					: off_w - phase_m2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_m2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (cfg_v.period == '0) begin
				led_q  <= '0;
				next_q <= '0;
				err_q  <= 1'b1;
			end else begin
				led_q  <= lit ? cfg_v.color_mask : '0;
				next_q <= next_d;
				err_q  <= 1'b0;
			end
		end
	end

	assign out_ch.valid           = out_vld_q;
	assign out_ch.led_enable      = led_q;
	assign out_ch.ticks_to_change = next_q;
	assign out_ch.period_error    = err_q;

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_vld_q || out_ch.ready))
		else $error("input ready does not follow output stall");
	a_err_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && err_q |-> led_q == '0 && next_q == '0)
		else $error("period error item not dark");
	a_next_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !err_q |-> next_q != '0)
		else $error("zero ticks to change without error");
	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(out_vld_q))
		else $error("pipeline moved during stall");
endmodule
`default_nettype wire
